// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue; no dependencies.

package spq_pkg;

  // Action codes carried with each input word
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Status codes reported with each result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] prio;
    logic [31:0] payload;
  } entry_t;

  // Logical slot that the read port looks at
  typedef enum logic [1:0] {
    RD_TOP    = 2'd0,  // last held entry
    RD_BELOW  = 2'd1,  // one below the scan index
    RD_HEAD   = 2'd2,  // first held entry
    RD_SECOND = 2'd3   // second held entry
  } rd_mode_e;

  // What the write port stores
  typedef enum logic [1:0] {
    WR_NONE      = 2'd0,
    WR_SHIFT     = 2'd1,  // read entry moves up one slot
    WR_NEW_ABOVE = 2'd2,  // new entry lands above the scan index
    WR_NEW_AT    = 2'd3   // new entry lands at the scan index
  } wr_mode_e;

  // Scan index update
  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_TOP  = 2'd1,
    IDX_DEC  = 2'd2,
    IDX_CLR  = 2'd3
  } idx_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    idx_op_e    idx_op;
    rd_mode_e   rd_mode;
    wr_mode_e   wr_mode;
    logic       take_head;
    logic       fin;
    logic [1:0] fin_status;
    logic       fin_deq;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic ge;        // read entry priority >= new priority
    logic idx_zero;
  } sts_t;

endpackage

// ===== hdl/spq_datapath.sv =====
// Datapath of the sorted priority queue: entry ring memory, scan index,
// count, min/max tracking and result registers. Depends on spq_pkg.

module spq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cmd_t       cmd_i,
  output spq_pkg::sts_t       sts_o,
  input  logic signed [31:0]  item_value_i,
  input  logic signed [31:0]  item_priority_i,
  input  logic        [31:0]  item_payload_i,
  output logic                done_o,
  output logic        [1:0]   status_o,
  output logic signed [31:0]  out_value_o,
  output logic signed [31:0]  out_priority_o,
  output logic        [31:0]  out_payload_o,
  output logic        [4:0]   entry_total_o,
  output logic signed [31:0]  lowest_priority_o,
  output logic signed [31:0]  highest_priority_o
);
  import spq_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned Depth = 1 << AW;

  entry_t             mem_q [Depth];
  entry_t             rd_q;
  entry_t             item_q;
  entry_t             taken_q;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [31:0] low_q, low_d;
  logic signed [31:0] high_q, high_d;
  logic               done_q;
  logic [1:0]         status_q;
  entry_t             res_entry_q;
  logic [4:0]         total_q;
  logic signed [31:0] res_low_q, res_high_q;

  logic [AW-1:0]      rd_log, wr_log;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               we;
  entry_t             wdata;
  logic [CW-1:0]      cnt_inc, cnt_dec;
  logic signed [31:0] new_pri;

  assign cnt_inc = count_q + CW'(1);
  assign cnt_dec = count_q - CW'(1);
  assign new_pri = $signed(item_q.prio);

  // Status toward the controller
  assign sts_o.full     = (count_q >= CW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.ge       = ($signed(rd_q.prio) >= new_pri);
  assign sts_o.idx_zero = (idx_q == '0);

  // Select the logical read slot
  always_comb begin
    unique case (cmd_i.rd_mode)
      RD_TOP:    rd_log = AW'(cnt_dec);
      RD_BELOW:  rd_log = idx_q - AW'(1);
      RD_HEAD:   rd_log = '0;
      RD_SECOND: rd_log = AW'(1);
      default:   rd_log = '0;
    endcase
  end
  assign rd_addr = head_q + rd_log;

  // Select the write slot and data
  always_comb begin
    we     = 1'b0;
    wr_log = idx_q;
    wdata  = item_q;
    unique case (cmd_i.wr_mode)
      WR_NONE: begin
        we = 1'b0;
      end
      WR_SHIFT: begin
        we     = 1'b1;
        wr_log = idx_q + AW'(1);
        wdata  = rd_q;
      end
      WR_NEW_ABOVE: begin
        we     = 1'b1;
        wr_log = idx_q + AW'(1);
      end
      WR_NEW_AT: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end
  assign wr_addr = head_q + wr_log;

  // Entry ring memory, one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (we) begin
      mem_q[wr_addr] <= wdata;
    end
  end

  // Hold the accepted word and the removed head entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= '{value: item_value_i, prio: item_priority_i, payload: item_payload_i};
    end
    if (cmd_i.take_head) begin
      taken_q <= rd_q;
    end
  end

  // Scan index
  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_TOP:  idx_d = AW'(cnt_dec);
      IDX_DEC:  idx_d = idx_q - AW'(1);
      IDX_CLR:  idx_d = '0;
      default:  idx_d = idx_q;
    endcase
  end

  // Next count, head and min/max at the end of an operation
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    low_d   = low_q;
    high_d  = high_q;
    if (cmd_i.fin && (cmd_i.fin_status == ST_OK)) begin
      if (cmd_i.fin_deq) begin
        head_d  = head_q + AW'(1);
        count_d = cnt_dec;
        if (cnt_dec == '0) begin
          low_d  = '0;
          high_d = '0;
        end else begin
          low_d  = $signed(rd_q.prio);
        end
      end else begin
        count_d = cnt_inc;
        if (count_q == '0) begin
          low_d  = new_pri;
          high_d = new_pri;
        end else begin
          if (new_pri < low_q) begin
            low_d = new_pri;
          end
          if (new_pri > high_q) begin
            high_d = new_pri;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      idx_q   <= '0;
      count_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
      done_q  <= cmd_i.fin;
    end
  end

  // Result word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_q   <= cmd_i.fin_status;
      total_q    <= 5'(count_d);
      res_low_q  <= low_d;
      res_high_q <= high_d;
      if (cmd_i.fin_deq && (cmd_i.fin_status == ST_OK)) begin
        res_entry_q <= taken_q;
      end else begin
        res_entry_q <= '0;
      end
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign out_value_o        = $signed(res_entry_q.value);
  assign out_priority_o     = $signed(res_entry_q.prio);
  assign out_payload_o      = res_entry_q.payload;
  assign entry_total_o      = total_q;
  assign lowest_priority_o  = res_low_q;
  assign highest_priority_o = res_high_q;

endmodule

// ===== hdl/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue: sequences scans,
// inserts and removals through command words. Depends on spq_pkg.

module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          action_i,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import spq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EQ_SCAN = 5'b00010,
    S_EQ_PUT  = 5'b00100,
    S_DQ_HEAD = 5'b01000,
    S_DQ_NEXT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and command
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.rd_mode    = RD_HEAD;
    cmd_o.wr_mode    = WR_NONE;
    cmd_o.fin_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (action_i == ACT_ENQ) begin
            if (sts_i.full) begin
              cmd_o.fin        = 1'b1;
              cmd_o.fin_status = ST_FULL;
            end else if (sts_i.empty) begin
              cmd_o.idx_op = IDX_CLR;
              state_d      = S_EQ_PUT;
            end else begin
              cmd_o.idx_op  = IDX_TOP;
              cmd_o.rd_mode = RD_TOP;
              state_d       = S_EQ_SCAN;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.fin        = 1'b1;
              cmd_o.fin_status = ST_EMPTY;
            end else begin
              cmd_o.rd_mode = RD_HEAD;
              state_d       = S_DQ_HEAD;
            end
          end
        end
      end
      // Walk down from the tail, moving entries up until a lower priority shows
      S_EQ_SCAN: begin
        if (sts_i.ge) begin
          cmd_o.wr_mode = WR_SHIFT;
          if (sts_i.idx_zero) begin
            state_d = S_EQ_PUT;
          end else begin
            cmd_o.idx_op  = IDX_DEC;
            cmd_o.rd_mode = RD_BELOW;
          end
        end else begin
          cmd_o.wr_mode = WR_NEW_ABOVE;
          cmd_o.fin     = 1'b1;
          state_d       = S_IDLE;
        end
      end
      // Place the new entry at the front
      S_EQ_PUT: begin
        cmd_o.wr_mode = WR_NEW_AT;
        cmd_o.fin     = 1'b1;
        state_d       = S_IDLE;
      end
      // Capture the head, fetch the one behind it
      S_DQ_HEAD: begin
        cmd_o.take_head = 1'b1;
        cmd_o.rd_mode   = RD_SECOND;
        state_d         = S_DQ_NEXT;
      end
      S_DQ_NEXT: begin
        cmd_o.fin     = 1'b1;
        cmd_o.fin_deq = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Channel  | Ports                                       | Handshake
// -------- | ------------------------------------------- | -------------------------
// input    | action_i, item_value_i, item_priority_i,    | start_i high, busy_o low
//          | item_payload_i                              |
// result   | status_o, out_value_o, out_priority_o,      | done_o high for one cycle
//          | out_payload_o, entry_total_o,               |
//          | lowest_priority_o, highest_priority_o       |
//
// Top level of the min-first sorted priority queue; depends on spq_pkg,
// spq_ctrl and spq_datapath.
// Order: a rejected enqueue or an empty dequeue reports in the cycle after
// acceptance; a dequeue reports after states S_DQ_HEAD and S_DQ_NEXT; an enqueue
// reports once S_EQ_SCAN has moved up each held entry with priority at or above
// the new one, one entry a cycle through the memory port, and the new one is written.
// busy_o drops in the cycle done_o is high, so a new word may be taken there.
// Reset clears count, head pointer and min/max; no memory clear is needed.
// The receiver cannot stall; each result word shows for exactly one cycle.

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                action_i,
  input  logic signed [31:0]  item_value_i,
  input  logic signed [31:0]  item_priority_i,
  input  logic        [31:0]  item_payload_i,
  output logic                done_o,
  output logic        [1:0]   status_o,
  output logic signed [31:0]  out_value_o,
  output logic signed [31:0]  out_priority_o,
  output logic        [31:0]  out_payload_o,
  output logic        [4:0]   entry_total_o,
  output logic signed [31:0]  lowest_priority_o,
  output logic signed [31:0]  highest_priority_o
);
  import spq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .item_value_i       (item_value_i),
    .item_priority_i    (item_priority_i),
    .item_payload_i     (item_payload_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .out_value_o        (out_value_o),
    .out_priority_o     (out_priority_o),
    .out_payload_o      (out_payload_o),
    .entry_total_o      (entry_total_o),
    .lowest_priority_o  (lowest_priority_o),
    .highest_priority_o (highest_priority_o)
  );

  // An enqueue while full is rejected in the next cycle
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (action_i == ACT_ENQ) && sts.full
    |=> done_o && (status_o == ST_FULL))
    else $error("full enqueue not rejected");

  // An empty dequeue reports nothing held and no entry
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY)
    |-> (entry_total_o == 5'd0) && (out_value_o == 32'sd0) && (out_payload_o == 32'd0))
    else $error("empty dequeue reported data");

  // Held priorities stay ordered
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (entry_total_o != 5'd0) |-> (lowest_priority_o <= highest_priority_o))
    else $error("lowest priority above highest");

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: directed table, then random words.
// Depends on spq_pkg and the sorted_priority_queue RTL. Every result is compared
// with the typed table expectation, or else with an in-bench sorted-list model.

module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int QCAP       = 16;
  localparam int N_RANDOM   = 1626;
  localparam int STALL_MAX  = 2000;  // cycles with no word moving before giving up
  localparam int DRAIN_WAIT = 3 * QCAP + 8;

  // One held entry of the model
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic        [31:0] payload;
  } slot_t;

  // One result word
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic        [31:0] payload;
    logic        [4:0]  total;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } qres_t;

  // One row of the directed table
  typedef struct {
    logic        act;
    logic [31:0] value;
    logic [31:0] prio;
    logic [31:0] payload;
    bit          typed;
    qres_t       want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               action_i;
  logic signed [31:0] item_value_i;
  logic signed [31:0] item_priority_i;
  logic        [31:0] item_payload_i;
  logic               done_o;
  logic        [1:0]  status_o;
  logic signed [31:0] out_value_o;
  logic signed [31:0] out_priority_o;
  logic        [31:0] out_payload_o;
  logic        [4:0]  entry_total_o;
  logic signed [31:0] lowest_priority_o;
  logic signed [31:0] highest_priority_o;

  // Typed expectation that travels with a directed word
  bit    row_typed;
  qres_t row_want;

  slot_t held_slots[$];
  qres_t pending_results[$];
  row_t  dir_tab[$];
  int    errors;
  int    results_seen;
  int    quiet_cycles;

  sorted_priority_queue #(.CAPACITY(QCAP)) dut (.*);

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Apply one word to the sorted list and return the result it must give
  function automatic qres_t queue_apply(logic a, logic signed [31:0] v,
                                        logic signed [31:0] p, logic [31:0] pl);
    qres_t r;
    slot_t s;
    int    pos;
    r = '0;
    r.status = ST_OK;
    if (a == ACT_ENQ) begin
      if (held_slots.size() >= QCAP) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // land ahead of equal priorities
        while (pos < held_slots.size() && held_slots[pos].prio < p) pos++;
        s.value = v;
        s.prio = p;
        s.payload = pl;
        held_slots.insert(pos, s);
      end
    end else if (held_slots.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      s = held_slots.pop_front();
      r.value = s.value;
      r.prio = s.prio;
      r.payload = s.payload;
    end
    r.total = 5'(held_slots.size());
    if (held_slots.size() != 0) begin
      r.low = held_slots[0].prio;
      r.high = held_slots[held_slots.size() - 1].prio;
    end
    return r;
  endfunction

  function automatic qres_t mk_res(logic [1:0] st, logic [31:0] v, logic [31:0] p,
                                   logic [31:0] pl, logic [4:0] tot,
                                   logic [31:0] lo, logic [31:0] hi);
    qres_t r;
    r.status = st;
    r.value = v;
    r.prio = p;
    r.payload = pl;
    r.total = tot;
    r.low = lo;
    r.high = hi;
    return r;
  endfunction

  task automatic add_row(logic a, logic [31:0] v, logic [31:0] p, logic [31:0] pl,
                         bit typed, qres_t want);
    row_t row;
    row.act = a;
    row.value = v;
    row.prio = p;
    row.payload = pl;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  task automatic flag(string msg);
    errors++;
    $display("tb: mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Present one word and hold it until the queue takes it
  task automatic send_word(logic a, logic [31:0] v, logic [31:0] p, logic [31:0] pl,
                           bit typed, qres_t want);
    @(negedge clk_i);
    start_i <= 1'b1;
    action_i <= a;
    item_value_i <= v;
    item_priority_i <= p;
    item_payload_i <= pl;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Check result words, predict accepted words, and watch for a hang
  always @(posedge clk_i) begin
    qres_t want;
    qres_t pred;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          flag("result word with nothing pending");
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(status_o), 32'(want.status));
          check_field("out_value", out_value_o, want.value);
          check_field("out_priority", out_priority_o, want.prio);
          check_field("out_payload", out_payload_o, want.payload);
          check_field("entry_total", 32'(entry_total_o), 32'(want.total));
          check_field("lowest_priority", lowest_priority_o, want.low);
          check_field("highest_priority", highest_priority_o, want.high);
        end
        results_seen++;
      end
      if (start_i && !busy_o) begin
        pred = queue_apply(action_i, item_value_i, item_priority_i, item_payload_i);
        pending_results.push_back(row_typed ? row_want : pred);
      end
      if (done_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_prio();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 6)) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  initial begin
    int    burst_left;
    int    mode;
    int    enq_pct;
    logic  a;
    qres_t none;
    errors = 0;
    results_seen = 0;
    quiet_cycles = 0;
    none = '0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = ACT_ENQ;
    item_value_i = '0;
    item_priority_i = '0;
    item_payload_i = '0;
    row_typed = 1'b0;
    row_want = '0;

    // Directed table: empty, extremes, ties, then fill to the brim and beyond
    add_row(ACT_DEQ, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
            mk_res(ST_EMPTY, 32'd0, 32'd0, 32'd0, 5'd0, 32'd0, 32'd0));
    add_row(ACT_ENQ, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
            mk_res(ST_OK, 32'd0, 32'd0, 32'd0, 5'd1, 32'h7fff_ffff, 32'h7fff_ffff));
    add_row(ACT_ENQ, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1,
            mk_res(ST_OK, 32'd0, 32'd0, 32'd0, 5'd2, 32'h8000_0000, 32'h7fff_ffff));
    add_row(ACT_ENQ, 32'd1, 32'd5, 32'd1, 1'b0, none);
    add_row(ACT_ENQ, 32'd2, 32'd5, 32'd2, 1'b0, none);
    add_row(ACT_DEQ, 32'd0, 32'd0, 32'd0, 1'b1,
            mk_res(ST_OK, 32'h8000_0000, 32'h8000_0000, 32'd0, 5'd3, 32'd5,
                   32'h7fff_ffff));
    add_row(ACT_DEQ, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, none);
    for (int i = 0; i < QCAP - 2; i++) begin
      case (i % 4)
        0: add_row(ACT_ENQ, 32'h100 + i, 32'h8000_0000, ~i, 1'b0, none);
        1: add_row(ACT_ENQ, 32'h100 + i, 32'hffff_ffff, ~i, 1'b0, none);
        2: add_row(ACT_ENQ, 32'h100 + i, 32'h7fff_ffff, ~i, 1'b0, none);
        default: add_row(ACT_ENQ, 32'h100 + i, 32'(i - 7), ~i, 1'b0, none);
      endcase
    end
    add_row(ACT_ENQ, 32'hdead_beef, 32'h0000_0000, 32'hcafe_f00d, 1'b0, none);
    add_row(ACT_DEQ, 32'd0, 32'd0, 32'd0, 1'b0, none);
    add_row(ACT_ENQ, 32'h1234_5678, 32'h7fff_ffff, 32'h8765_4321, 1'b0, none);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table back to back, then with gaps on a second half
    foreach (dir_tab[i]) begin
      if (i > 12 && $urandom_range(0, 2) == 0) idle($urandom_range(1, 3));
      send_word(dir_tab[i].act, dir_tab[i].value, dir_tab[i].prio, dir_tab[i].payload,
                dir_tab[i].typed, dir_tab[i].want);
    end

    // Random words: fill, drain and balanced phases, sent in bursts
    burst_left = 0;
    mode = 0;
    enq_pct = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 32 == 0) begin
        mode = $urandom_range(0, 2);
        enq_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      end
      if (burst_left == 0) begin
        idle($urandom_range(1, 5));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      a = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
      send_word(a, $urandom(), pick_prio(), $urandom(), 1'b0, none);
    end

    // Drain, then give the queue time to show any stray word
    idle(1);
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue.f =====
hdl/spq_pkg.sv
hdl/spq_datapath.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
